>>> rtl/core/spq_pkg.sv
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

  // value width of one stored entry
  localparam int VALUE_W = 32;

  // operation codes carried on in_tuser
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load;   // capture compare flags into the walk chain
    logic shift;  // move walk flags one cell toward the head
    logic ins;    // open a slot and insert the key
    logic rem;    // close the slot of the first equal entry
  } cell_op_t;

  // what one cell shows its neighbors
  typedef struct packed {
    value_t value;
    logic   occ;   // cell holds an entry
    logic   gt;    // entry is greater than the key
    logic   mark;  // walk flag: greater than key
    logic   hit;   // walk flag: equal to key
  } cell_link_t;

endpackage

`default_nettype wire

>>> rtl/core/spq_cell.sv
// one storage cell of the sorted chain
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_op_t   op,
  input  wire value_t     key,
  input  wire cell_link_t up_lnk,   // neighbor nearer the head
  input  wire cell_link_t dn_lnk,   // neighbor farther from the head
  output cell_link_t      self_lnk
);

  value_t val_r, val_nxt;
  logic   occ_r, occ_nxt;
  logic   mark_r, mark_nxt;
  logic   hit_r, hit_nxt;
  logic   gt;
  logic   eq;

  // local compare against the broadcast key
  assign gt = occ_r && (val_r > key);
  assign eq = occ_r && (val_r == key);

  // entry update: keep greater entries, shift the rest
  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (op.ins && !gt) begin
      val_nxt = up_lnk.gt ? key : up_lnk.value;
      occ_nxt = occ_r | up_lnk.occ;
    end else if (op.rem && !gt) begin
      val_nxt = dn_lnk.value;
      occ_nxt = dn_lnk.occ;
    end
  end

  // walk flags: load from compare, then drift toward the head
  always_comb begin
    mark_nxt = mark_r;
    hit_nxt  = hit_r;
    if (op.load) begin
      mark_nxt = gt;
      hit_nxt  = eq;
    end else if (op.shift) begin
      mark_nxt = dn_lnk.mark;
      hit_nxt  = dn_lnk.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    mark_r <= mark_nxt;
    hit_r  <= hit_nxt;
  end

  assign self_lnk.value = val_r;
  assign self_lnk.occ   = occ_r;
  assign self_lnk.gt    = gt;
  assign self_lnk.mark  = mark_r;
  assign self_lnk.hit   = hit_r;

endmodule

`default_nettype wire

>>> rtl/core/sorted_priority_queue_unit.sv
// top level of the sorted priority queue: cell chain and sequencer
//
//  channel | ports                   | word contents (lowest bit up)
//  --------+-------------------------+------------------------------------------
//  input   | in_tvalid/tready/tdata  | tdata: value[31:0]; tuser: kind[1:0]
//  result  | out_tvalid/tready/tdata | success, position[3:0], count[4:0],
//          |                         | head_value[31:0], head_valid, zero fill
//
//  the sequencer steps through compare, walk, update and result states, then
//  takes the next word; out_tvalid rises as the result state loads the output
//  register; the compare flags walk toward the head one cell per cycle to count
//  k, the stored entries greater than the value (at most the entry count)
//  reset clears the entry count and cell occupancy; entry values are not cleared
//  the result sits in an output register and the next word may be accepted while
//  it waits; that word then holds the sequencer in its result state until the
//  register is taken
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // success, position[4:1], count[9:5],
                                       // head_value[41:10], head_valid[42]
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    kind_r;
  value_t        key_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic          found_r, found_nxt;
  logic          ok_r, ok_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r;
  logic          full;
  logic          in_fire;
  logic          res_load;
  cell_op_t      op;
  cell_link_t    lnk [DEPTH];
  cell_link_t    head_lnk;
  cell_link_t    tail_lnk;
  logic [DEPTH-1:0] occ_vec;
  logic [31:0]   pos_ext;
  logic [31:0]   cnt_ext;

  assign full      = (count_r == CW'(DEPTH));
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign res_load  = (state_r == S_RES) && (!out_valid_r || out_tready);

  // boundary links: an always-greater slot before the head, an empty one past the tail
  always_comb begin
    head_lnk       = '0;
    head_lnk.occ   = 1'b1;
    head_lnk.gt    = 1'b1;
    tail_lnk       = '0;
  end

  // commands to the cells
  always_comb begin
    op       = '0;
    op.load  = (state_r == S_CMP);
    op.shift = (state_r == S_WALK) && lnk[0].mark;
    op.ins   = (state_r == S_UPD) && (kind_r == KIND_INSERT) && !full;
    op.rem   = (state_r == S_UPD) && (kind_r == KIND_REMOVE) && found_r;
  end

  // cell chain
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_link_t up_w;
      cell_link_t dn_w;
      if (gi == 0) begin : g_first
        assign up_w = head_lnk;
      end else begin : g_mid_up
        assign up_w = lnk[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign dn_w = tail_lnk;
      end else begin : g_mid_dn
        assign dn_w = lnk[gi+1];
      end
      spq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .key      (key_r),
        .up_lnk   (up_w),
        .dn_lnk   (dn_w),
        .self_lnk (lnk[gi])
      );
      assign occ_vec[gi] = lnk[gi].occ;
    end
  endgenerate

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    walk_nxt  = walk_r;
    found_nxt = found_r;
    ok_nxt    = ok_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        walk_nxt  = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (lnk[0].mark) begin
          walk_nxt = walk_r + 1'b1;
        end else begin
          found_nxt = lnk[0].hit;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        case (kind_r)
          KIND_INSERT: ok_nxt = !full;
          KIND_REMOVE: ok_nxt = found_r;
          KIND_FIND:   ok_nxt = found_r;
          default:     ok_nxt = 1'b0;
        endcase
        pos_nxt = ok_nxt ? walk_r : '0;
        if (op.ins) begin
          count_nxt = count_r + 1'b1;
        end else if (op.rem) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // operand and walk payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      key_r  <= value_t'(in_tdata);
    end
    walk_r  <= walk_nxt;
    found_r <= found_nxt;
    ok_r    <= ok_nxt;
    pos_r   <= pos_nxt;
  end

  // output register
  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(count_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {5'd0,
                     lnk[0].occ,
                     lnk[0].occ ? lnk[0].value : value_t'(0),
                     cnt_ext[4:0],
                     pos_ext[3:0],
                     ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_occ_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == 32'(count_r))
    else $error("cell occupancy disagrees with entry count");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (walk_r <= count_r))
    else $error("walk ran past the stored entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not add one entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    op.rem |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove did not drop one entry");

endmodule

`default_nettype wire

>>> tb/sorted_priority_queue_unit_test.sv
// self-checking testbench for the sorted priority queue unit
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_WORDS = 262;
  localparam int SETTLE_CYCLES = 40;

  // reply fields in the same bit order as out_tdata[42:0]
  typedef struct packed {
    logic       head_valid;
    value_t     head_value;
    logic [4:0] count;
    logic [3:0] position;
    logic       success;
  } reply_t;

  // shadow copy of the queue and the replies still owed by the block
  class priority_queue_checker;
    value_t      stored[QUEUE_DEPTH];
    int unsigned n_stored;
    reply_t      expected_replies[$];
    int unsigned errors;

    function new();
      n_stored = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function value_t entry_at(int unsigned idx);
      return stored[idx];
    endfunction

    // first stored index equal to v, or n_stored when absent
    function int unsigned first_equal(value_t v);
      for (int unsigned i = 0; i < n_stored; i++) begin
        if (stored[i] == v) return i;
      end
      return n_stored;
    endfunction

    // apply one accepted word to the shadow queue and queue its reply
    function void predict_op(logic [1:0] kind, value_t v);
      reply_t      r;
      int unsigned at;
      r = '0;
      case (kind)
        KIND_INSERT: begin
          if (n_stored < QUEUE_DEPTH) begin
            at = n_stored;
            for (int unsigned i = 0; i < n_stored; i++) begin
              if (stored[i] <= v) begin
                at = i;
                break;
              end
            end
            for (int unsigned i = n_stored; i > at; i--) stored[i] = stored[i - 1];
            stored[at] = v;
            n_stored++;
            r.success = 1'b1;
            r.position = at[3:0];
          end
        end
        KIND_REMOVE: begin
          at = first_equal(v);
          if (at < n_stored) begin
            for (int unsigned i = at; i + 1 < n_stored; i++) stored[i] = stored[i + 1];
            n_stored--;
            r.success = 1'b1;
            r.position = at[3:0];
          end
        end
        KIND_FIND: begin
          at = first_equal(v);
          if (at < n_stored) begin
            r.success = 1'b1;
            r.position = at[3:0];
          end
        end
        default: begin
          // unused kind leaves the queue alone
        end
      endcase
      r.count = n_stored[4:0];
      r.head_valid = (n_stored > 0);
      r.head_value = (n_stored > 0) ? stored[0] : '0;
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one result word with the oldest expectation
    function void check_reply(logic [47:0] word);
      reply_t exp_r;
      reply_t act_r;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, word);
        errors++;
        return;
      end
      exp_r = expected_replies.pop_front();
      act_r = reply_t'(word[42:0]);
      compare_field("success", exp_r.success, act_r.success);
      compare_field("position", exp_r.position, act_r.position);
      compare_field("count", exp_r.count, act_r.count);
      compare_field("head_value", exp_r.head_value, act_r.head_value);
      compare_field("head_valid", exp_r.head_valid, act_r.head_valid);
      compare_field("zero fill", 0, word[47:43]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // value[31:0]
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // success, position[4:1], count[9:5],
                                // head_value[41:10], head_valid[42]

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  priority_queue_checker pq_check = new();

  sorted_priority_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // receiver: random stalls set at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result words are checked as they are taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pq_check.check_reply(out_tdata);
  end

  // send one word, called at a falling edge, returns at a falling edge
  task automatic push_word(input logic [1:0] kind, input value_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pq_check.predict_op(kind, v);
    @(negedge clk);
  endtask

  // hold the sender until every owed result has come back
  task automatic drain_replies();
    while (pq_check.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // operand mix: stored entries, a small dense range, extremes, anything
  function automatic value_t pick_value();
    int unsigned r;
    value_t edge_vals[7];
    edge_vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7ffffffe, 32'sh80000001};
    r = $urandom_range(0, 99);
    if (r < 35 && pq_check.n_stored > 0)
      return pq_check.entry_at($urandom_range(0, pq_check.n_stored - 1));
    if (r < 60) return value_t'($signed($urandom_range(0, 15)) - 8);
    if (r < 70) return edge_vals[$urandom_range(0, 6)];
    return value_t'($urandom);
  endfunction

  // run shutoff
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    int unsigned r;
    bit          fill_mode;
    logic [1:0]  kind;

    idle_set = '{0, 47, 0, 35};
    stall_set = '{0, 0, 47, 35};

    // synchronous reset
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty queue, extremes, duplicates, absent values, full store
    push_word(KIND_FIND, 5);
    push_word(KIND_REMOVE, 5);
    push_word(KIND_INSERT, 32'sh7fffffff);
    push_word(KIND_INSERT, 32'sh80000000);
    push_word(KIND_INSERT, 0);
    push_word(KIND_INSERT, 0);
    push_word(KIND_FIND, 0);
    push_word(KIND_FIND, 7);
    push_word(KIND_REMOVE, 32'sh80000000);
    push_word(KIND_REMOVE, 9);
    for (int i = 0; i < 13; i++) push_word(KIND_INSERT, value_t'(i * 37 - 200));
    push_word(KIND_INSERT, 32'sh7fffffff);
    push_word(KIND_UNUSED, 32'hffffffff);
    push_word(KIND_REMOVE, 32'sh7fffffff);
    in_tvalid <= 1'b0;
    drain_replies();

    // random phases with different idling on each side
    fill_mode = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) fill_mode = ~fill_mode;
        r = $urandom_range(0, 99);
        if (r < 4) kind = KIND_UNUSED;
        else if (r < (fill_mode ? 64 : 34)) kind = KIND_INSERT;
        else if (r < (fill_mode ? 82 : 74)) kind = KIND_REMOVE;
        else kind = KIND_FIND;
        push_word(kind, pick_value());
      end
      in_tvalid <= 1'b0;
      drain_replies();
    end

    // let any stray result word show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pq_check.errors == 0 && pq_check.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sorted_priority_queue_unit.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_test.sv
